>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands. Each expects signals named clock and
// reset (synchronous, active high) in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/lesf_pkg.sv
// ----------------------------------------------------------------------------
// lesf_pkg
// Shared widths, reset values, register indexes and types of the largest
// empty square finder.
// ----------------------------------------------------------------------------
package lesf_pkg;

   localparam int OBS_W    = 8;
   localparam int COLS_W   = 11;
   localparam int SIZE_W   = 11;
   localparam int TOP_W    = 16;
   localparam int LEFT_W   = 10;
   localparam int ARITH_W  = 32;
   localparam int CSR_IDX_W = 1;

   // a row never uses more line entries than this, whatever the map width
   localparam int COUNT_CAP       = 1024;
   localparam int DEF_MAX_COLUMNS = 1024;
   localparam int DEF_MAX_ROWS    = 65536;

   localparam logic [OBS_W-1:0]  OBS_RESET  = 8'd111;
   localparam logic [COLS_W-1:0] COLS_RESET = 11'd1024;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OBSTACLE = 1'b0,
      CSR_COLUMNS  = 1'b1
   } csr_index_type;

   // per-cell flags handed from the front end to the size stage
   typedef struct packed {
      logic first_row;
      logic first_col;
      logic ovf;
      logic last;
      logic obs;
   } cell_flags_type;

   function automatic logic [SIZE_W-1:0] min3(input logic [SIZE_W-1:0] a,
                                              input logic [SIZE_W-1:0] b,
                                              input logic [SIZE_W-1:0] c);
      logic [SIZE_W-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

endpackage

>>> hw/rtl/lesf_req_if.sv
// ----------------------------------------------------------------------------
// lesf_req_if
// Map cell channel: one character per item plus an end-of-map mark.
// ----------------------------------------------------------------------------
interface lesf_req_if import lesf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OBS_W-1:0] cell_char;
   logic             last_cell;

   modport source (output valid, output cell_char, output last_cell, input ready);
   modport sink   (input valid, input cell_char, input last_cell, output ready);
endinterface

>>> hw/rtl/lesf_rsp_if.sv
// ----------------------------------------------------------------------------
// lesf_rsp_if
// Result channel: corner and side of the largest empty square.
// ----------------------------------------------------------------------------
interface lesf_rsp_if import lesf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TOP_W-1:0]  top_row;
   logic [LEFT_W-1:0] left_column;
   logic [SIZE_W-1:0] side_length;
   logic              too_tall;

   modport source (output valid, output top_row, output left_column,
                   output side_length, output too_tall, input ready);
   modport sink   (input valid, input top_row, input left_column,
                   input side_length, input too_tall, output ready);
endinterface

>>> hw/rtl/lesf_ram.sv
// ----------------------------------------------------------------------------
// lesf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lesf_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/lesf_front.sv
// ----------------------------------------------------------------------------
// lesf_front
// Configuration registers, row/column scan counters and the line read.
// Registers each accepted cell into the size stage.
// ----------------------------------------------------------------------------
module lesf_front import lesf_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   localparam int LINE_DEPTH = (MAX_COLUMNS < COUNT_CAP) ? MAX_COLUMNS : COUNT_CAP,
   localparam int CW         = $clog2(LINE_DEPTH),
   localparam int RW         = $clog2(MAX_ROWS + 1),
   localparam int RBW        = $clog2(MAX_ROWS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  csr_index_type         csr_index,
   input  logic [COLS_W-1:0]     csr_write_data,
   lesf_req_if.sink              req_ch,
   input  logic                  advance,
   output logic                  rd_en,
   output logic [CW-1:0]         rd_addr,
   output logic                  s1_valid,
   output logic [CW-1:0]         s1_col,
   output logic [RBW-1:0]        s1_row,
   output cell_flags_type        s1_flags
);

   logic [OBS_W-1:0]  obs_ff;
   logic [COLS_W-1:0] cols_cfg_ff;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [CW-1:0]     s1_col_ff;
   logic [RBW-1:0]    s1_row_ff;
   cell_flags_type    s1_flags_ff, flags;

   logic [CW:0]   cols;
   logic [CW:0]   col_next;
   logic          accept, pre_wrap, post_wrap;
   logic [CW-1:0] cur_col;
   logic [RW-1:0] cur_row, row_after;

   always_ff @(posedge clock) begin
      if (reset) begin
         obs_ff      <= OBS_RESET;
         cols_cfg_ff <= COLS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_OBSTACLE: obs_ff      <= csr_write_data[OBS_W-1:0];
            CSR_COLUMNS:  cols_cfg_ff <= csr_write_data;
            default:      ;
         endcase
      end
   end

   // usable row width: zero acts as one, large values saturate to the line
   always_comb begin
      if (cols_cfg_ff == '0) begin
         cols = (CW+1)'(1);
      end else if (cols_cfg_ff > COLS_W'(LINE_DEPTH)) begin
         cols = (CW+1)'(LINE_DEPTH);
      end else begin
         cols = cols_cfg_ff[CW:0];
      end
   end

   assign accept = req_ch.valid & advance;
   assign req_ch.ready = advance;

   always_comb begin
      // column left out of range by a width change starts a new row at once
      pre_wrap = {1'b0, col_ff} >= cols;
      cur_col  = pre_wrap ? '0 : col_ff;
      cur_row  = (pre_wrap && (row_ff < RW'(MAX_ROWS))) ? row_ff + RW'(1) : row_ff;

      col_next  = {1'b0, cur_col} + (CW+1)'(1);
      post_wrap = col_next >= cols;
      row_after = (post_wrap && (cur_row < RW'(MAX_ROWS))) ? cur_row + RW'(1) : cur_row;

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (req_ch.last_cell) begin
            col_in = '0;
            row_in = '0;
         end else begin
            col_in = post_wrap ? '0 : col_next[CW-1:0];
            row_in = row_after;
         end
      end

      flags.first_row = (cur_row == '0);
      flags.first_col = (cur_col == '0);
      flags.ovf       = (cur_row >= RW'(MAX_ROWS));
      flags.last      = req_ch.last_cell;
      flags.obs       = (req_ch.cell_char == obs_ff);

      s1_valid_in = advance ? accept : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= cur_col;
         s1_row_ff   <= cur_row[RBW-1:0];
         s1_flags_ff <= flags;
      end
   end

   assign rd_en    = accept & ~flags.ovf;
   assign rd_addr  = cur_col;
   assign s1_valid = s1_valid_ff;
   assign s1_col   = s1_col_ff;
   assign s1_row   = s1_row_ff;
   assign s1_flags = s1_flags_ff;

endmodule

>>> hw/rtl/lesf_core.sv
// ----------------------------------------------------------------------------
// lesf_core
// Size stage: forms the cell size from the line entry above and the left
// and diagonal sizes, writes it back, tracks the best square and holds
// the result register.
// ----------------------------------------------------------------------------
module lesf_core import lesf_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   localparam int LINE_DEPTH = (MAX_COLUMNS < COUNT_CAP) ? MAX_COLUMNS : COUNT_CAP,
   localparam int CW         = $clog2(LINE_DEPTH),
   localparam int RBW        = $clog2(MAX_ROWS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              s1_valid,
   input  logic [CW-1:0]     s1_col,
   input  logic [RBW-1:0]    s1_row,
   input  cell_flags_type    s1_flags,
   input  logic              rd_issue,
   input  logic [CW-1:0]     rd_addr,
   input  logic [SIZE_W-1:0] rd_data,
   output logic              advance,
   output logic              wr_en,
   output logic [CW-1:0]     wr_addr,
   output logic [SIZE_W-1:0] wr_data,
   lesf_rsp_if.source        rsp_ch
);

   logic [SIZE_W-1:0] left_ff, diag_ff, best_size_ff;
   logic [RBW-1:0]    best_row_ff;
   logic [CW-1:0]     best_col_ff;
   logic              ovf_seen_ff;
   logic              fwd_ff;
   logic [SIZE_W-1:0] fwd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TOP_W-1:0]  top_ff;
   logic [LEFT_W-1:0] left_col_ff;
   logic [SIZE_W-1:0] side_ff;
   logic              too_tall_ff;

   logic              done, better, finish;
   logic [SIZE_W-1:0] up, size, fin_size;
   logic [RBW-1:0]    fin_row;
   logic [CW-1:0]     fin_col;
   logic [ARITH_W-1:0] top_full, left_full;

   // a last cell may only finish when the result register is free or being taken
   assign advance = ~(s1_valid & s1_flags.last & rsp_valid_ff & ~rsp_ch.ready);
   assign done    = s1_valid & advance;
   assign finish  = done & s1_flags.last;

   always_comb begin
      // entry written the cycle this one was read comes from the bypass
      up = fwd_ff ? fwd_data_ff : rd_data;
      if (s1_flags.obs) begin
         size = '0;
      end else if (s1_flags.first_row || s1_flags.first_col) begin
         size = SIZE_W'(1);
      end else begin
         size = min3(left_ff, up, diag_ff) + SIZE_W'(1);
      end

      wr_en   = done & ~s1_flags.ovf;
      wr_addr = s1_col;
      wr_data = size;
      better  = size > best_size_ff;

      if (wr_en && better) begin
         fin_size = size;
         fin_row  = s1_row;
         fin_col  = s1_col;
      end else begin
         fin_size = best_size_ff;
         fin_row  = best_row_ff;
         fin_col  = best_col_ff;
      end

      top_full  = ARITH_W'(fin_row) + ARITH_W'(1) - ARITH_W'(fin_size);
      left_full = ARITH_W'(fin_col) + ARITH_W'(1) - ARITH_W'(fin_size);

      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_size_ff <= '0;
         best_row_ff  <= '0;
         best_col_ff  <= '0;
         ovf_seen_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            fwd_ff <= rd_issue & wr_en & (rd_addr == s1_col);
         end
         if (finish) begin
            best_size_ff <= '0;
            best_row_ff  <= '0;
            best_col_ff  <= '0;
            ovf_seen_ff  <= 1'b0;
         end else begin
            if (wr_en && better) begin
               best_size_ff <= size;
               best_row_ff  <= s1_row;
               best_col_ff  <= s1_col;
            end
            if (done && s1_flags.ovf) begin
               ovf_seen_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= size;
      if (wr_en) begin
         left_ff <= size;
         diag_ff <= up;
      end
      if (finish) begin
         if (fin_size == '0) begin
            top_ff      <= '0;
            left_col_ff <= '0;
         end else begin
            top_ff      <= top_full[TOP_W-1:0];
            left_col_ff <= left_full[LEFT_W-1:0];
         end
         side_ff     <= fin_size;
         too_tall_ff <= ovf_seen_ff | s1_flags.ovf;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.top_row     = top_ff;
   assign rsp_ch.left_column = left_col_ff;
   assign rsp_ch.side_length = side_ff;
   assign rsp_ch.too_tall    = too_tall_ff;

endmodule

>>> hw/rtl/largest_empty_square_finder.sv
// ----------------------------------------------------------------------------
// largest_empty_square_finder
// Streams a character map in row-major order and reports the largest
// obstacle-free square on the last cell.
// ----------------------------------------------------------------------------
//   channel   direction   handshake      payload
//   req_ch    in          valid/ready    cell_char, last_cell
//   rsp_ch    out         valid/ready    top_row, left_column, side_length, too_tall
//   csr_*     in          write enable   csr_index, csr_write_data
//
// One cell per cycle while req_ch is not stalled; a cell is registered into the size
// stage and its result into the result register. The rate is set by the line buffer:
// one read and one write per cell, with a bypass when a row is one cell wide.
// Reset clears counters and best square; the line buffer needs no clearing.
// req_ch stalls only while a result is waiting and another last cell is
// ready to finish.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module largest_empty_square_finder import lesf_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   localparam int LINE_DEPTH = (MAX_COLUMNS < COUNT_CAP) ? MAX_COLUMNS : COUNT_CAP,
   localparam int CW         = $clog2(LINE_DEPTH),
   localparam int RBW        = $clog2(MAX_ROWS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  csr_index_type     csr_index,
   input  logic [COLS_W-1:0] csr_write_data,
   lesf_req_if.sink          req_ch,
   lesf_rsp_if.source        rsp_ch
);

   logic              advance;
   logic              rd_en;
   logic [CW-1:0]     rd_addr;
   logic [SIZE_W-1:0] rd_data;
   logic              wr_en;
   logic [CW-1:0]     wr_addr;
   logic [SIZE_W-1:0] wr_data;
   logic              s1_valid;
   logic [CW-1:0]     s1_col;
   logic [RBW-1:0]    s1_row;
   cell_flags_type    s1_flags;

   lesf_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_ch         (req_ch),
      .advance        (advance),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .s1_valid       (s1_valid),
      .s1_col         (s1_col),
      .s1_row         (s1_row),
      .s1_flags       (s1_flags)
   );

   lesf_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lesf_core #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_col   (s1_col),
      .s1_row   (s1_row),
      .s1_flags (s1_flags),
      .rd_issue (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .advance  (advance),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rsp_ch   (rsp_ch)
   );

   // a finishing last cell always leaves a result behind
   `ASSERT_NEXT(a_last_gives_result, s1_valid && s1_flags.last && advance, rsp_ch.valid)
   // input stalls only because a result is held
   `ASSERT_IMPL(a_stall_needs_result, !req_ch.ready, rsp_ch.valid && !rsp_ch.ready)
   // line writes come only from in-range cells
   `ASSERT_IMPL(a_write_in_range, wr_en, s1_valid && !s1_flags.ovf)

endmodule
